// File: rtl/hgmn_pkg.sv
// Shared constants and types for the heightmap mesh and normal unit.
package hgmn_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   localparam int SIZE_W      = 11;
   localparam int INV_W       = 17;
   localparam int HEIGHT_W    = 16;
   localparam int INDEX_W     = 20;
   localparam int TEX_W       = 16;
   localparam int NORM_W      = 21;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;

   localparam logic [INV_W-1:0] ONE_Q16 = 17'd65536;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_WIDTH  = 3'd0,
      CSR_GRID_HEIGHT = 3'd1,
      CSR_INV_WIDTH   = 3'd2,
      CSR_INV_HEIGHT  = 3'd3
   } hgmn_csr_index_type;

   // effective (clamped) configuration
   typedef struct packed {
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
      logic [INV_W-1:0]  inv_width;
      logic [INV_W-1:0]  inv_height;
   } hgmn_cfg_type;

   // one sample after the scan stage
   typedef struct packed {
      logic signed [HEIGHT_W-1:0] height;
      logic signed [HEIGHT_W-1:0] left;
      logic [INDEX_W-1:0]         index;
      logic                       face;
   } hgmn_item_type;

endpackage

// File: rtl/hgmn_csr.sv
// Configuration registers with clamping to effective values.
module hgmn_csr #(
   parameter int MAX_WIDTH  = hgmn_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = hgmn_pkg::DEF_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [hgmn_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hgmn_pkg::CSR_DATA_W-1:0]  csr_data,
   output hgmn_pkg::hgmn_cfg_type         cfg
);
   import hgmn_pkg::*;

   logic [SIZE_W-1:0] grid_width_ff;
   logic [SIZE_W-1:0] grid_height_ff;
   logic [INV_W-1:0]  inv_width_ff;
   logic [INV_W-1:0]  inv_height_ff;

   function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] v, int maxv);
      if (v == '0) return SIZE_W'(1);
      if (int'(v) > maxv) return SIZE_W'(maxv);
      return v;
   endfunction

   function automatic logic [INV_W-1:0] eff_inv(logic [INV_W-1:0] v);
      return (v > ONE_Q16) ? ONE_Q16 : v;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= SIZE_W'(1);
         grid_height_ff <= SIZE_W'(1);
         inv_width_ff   <= ONE_Q16;
         inv_height_ff  <= ONE_Q16;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_data[SIZE_W-1:0];
            CSR_GRID_HEIGHT: grid_height_ff <= csr_data[SIZE_W-1:0];
            CSR_INV_WIDTH:   inv_width_ff   <= csr_data[INV_W-1:0];
            CSR_INV_HEIGHT:  inv_height_ff  <= csr_data[INV_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.width      = eff_size(grid_width_ff, MAX_WIDTH);
      cfg.height     = eff_size(grid_height_ff, MAX_HEIGHT);
      cfg.inv_width  = eff_inv(inv_width_ff);
      cfg.inv_height = eff_inv(inv_height_ff);
   end

endmodule

// File: rtl/hgmn_row_mem.sv
// Row buffer: one height per column, read-first on a shared address.
module hgmn_row_mem #(
   parameter  int DEPTH  = hgmn_pkg::DEF_MAX_WIDTH,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                                 clock,
   input  logic                                 access_en,
   input  logic [ADDR_W-1:0]                    addr,
   input  logic signed [hgmn_pkg::HEIGHT_W-1:0] wr_data,
   output logic signed [hgmn_pkg::HEIGHT_W-1:0] rd_data_ff
);
   import hgmn_pkg::*;

   logic signed [HEIGHT_W-1:0] mem [DEPTH];

   // old entry comes out, new height goes in, same edge
   always_ff @(posedge clock) begin
      if (access_en) begin
         rd_data_ff <= mem[addr];
         mem[addr]  <= wr_data;
      end
   end

endmodule

// File: rtl/hgmn_arith.sv
// Multiply stage and rounding/output stage of the normal and texture math.
module hgmn_arith #(
   parameter  int MAX_WIDTH  = hgmn_pkg::DEF_MAX_WIDTH,
   parameter  int MAX_HEIGHT = hgmn_pkg::DEF_MAX_HEIGHT,
   localparam int COL_W      = $clog2(MAX_WIDTH),
   localparam int ROW_W      = $clog2(MAX_HEIGHT)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  hgmn_pkg::hgmn_cfg_type               cfg,
   input  logic                                 s1_valid,
   output logic                                 s1_ready,
   input  hgmn_pkg::hgmn_item_type              s1_item,
   input  logic [COL_W-1:0]                     s1_x,
   input  logic [ROW_W-1:0]                     s1_y,
   input  logic signed [hgmn_pkg::HEIGHT_W-1:0] s1_upper,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [hgmn_pkg::INDEX_W-1:0]         rsp_vertex_index,
   output logic [hgmn_pkg::TEX_W-1:0]           rsp_tex_u,
   output logic [hgmn_pkg::TEX_W-1:0]           rsp_tex_v,
   output logic signed [hgmn_pkg::HEIGHT_W-1:0] rsp_height_out,
   output logic signed [hgmn_pkg::NORM_W-1:0]   rsp_normal_x,
   output logic [hgmn_pkg::INV_W-1:0]           rsp_normal_y,
   output logic signed [hgmn_pkg::NORM_W-1:0]   rsp_normal_z,
   output logic                                 rsp_face_valid,
   output logic [hgmn_pkg::INDEX_W-1:0]         rsp_face_corner_a,
   output logic [hgmn_pkg::INDEX_W-1:0]         rsp_face_corner_b,
   output logic [hgmn_pkg::INDEX_W-1:0]         rsp_face_corner_c,
   output logic [hgmn_pkg::INDEX_W-1:0]         rsp_face_corner_d
);
   import hgmn_pkg::*;

   localparam int DIFF_W = HEIGHT_W + 1;
   localparam int NPROD_W = DIFF_W + INV_W + 1;
   localparam int TU_W = COL_W + INV_W;
   localparam int TV_W = ROW_W + INV_W;
   localparam int NY_W = 2 * INV_W;

   // multiply stage
   logic signed [DIFF_W-1:0]  diff_x;
   logic signed [DIFF_W-1:0]  diff_z;
   logic signed [INV_W:0]     ih_s;
   logic signed [INV_W:0]     iw_s;
   logic signed [NPROD_W-1:0] nx_prod;
   logic signed [NPROD_W-1:0] nz_prod;
   logic [TU_W-1:0]           tu_prod;
   logic [TV_W-1:0]           tv_prod;
   logic [NY_W-1:0]           ny_prod;

   logic                      s2_valid_ff;
   logic signed [NPROD_W-1:0] s2_nx_prod_ff;
   logic signed [NPROD_W-1:0] s2_nz_prod_ff;
   logic [TU_W-1:0]           s2_tu_prod_ff;
   logic [TV_W-1:0]           s2_tv_prod_ff;
   logic [NY_W-1:0]           s2_ny_prod_ff;
   logic signed [HEIGHT_W-1:0] s2_height_ff;
   logic [INDEX_W-1:0]        s2_index_ff;
   logic                      s2_face_ff;
   logic [INDEX_W-1:0]        s2_corner_a_ff;
   logic [INDEX_W-1:0]        s2_corner_b_ff;
   logic [INDEX_W-1:0]        s2_corner_d_ff;

   // output stage
   logic signed [NPROD_W-1:0] nx_sum;
   logic signed [NPROD_W-1:0] nz_sum;
   logic [NY_W-1:0]           ny_sum;
   logic                      out_ready;
   logic                      s2_ready;

   logic                       rsp_valid_ff;
   logic [INDEX_W-1:0]         rsp_vertex_index_ff;
   logic [TEX_W-1:0]           rsp_tex_u_ff;
   logic [TEX_W-1:0]           rsp_tex_v_ff;
   logic signed [HEIGHT_W-1:0] rsp_height_out_ff;
   logic signed [NORM_W-1:0]   rsp_normal_x_ff;
   logic [INV_W-1:0]           rsp_normal_y_ff;
   logic signed [NORM_W-1:0]   rsp_normal_z_ff;
   logic                       rsp_face_valid_ff;
   logic [INDEX_W-1:0]         rsp_face_corner_a_ff;
   logic [INDEX_W-1:0]         rsp_face_corner_b_ff;
   logic [INDEX_W-1:0]         rsp_face_corner_c_ff;
   logic [INDEX_W-1:0]         rsp_face_corner_d_ff;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = s2_ready;

   assign diff_x  = DIFF_W'(s1_item.left) - DIFF_W'(s1_item.height);
   assign diff_z  = DIFF_W'(s1_upper) - DIFF_W'(s1_item.height);
   assign ih_s    = {1'b0, cfg.inv_height};
   assign iw_s    = {1'b0, cfg.inv_width};
   assign nx_prod = diff_x * ih_s;
   assign nz_prod = diff_z * iw_s;
   assign tu_prod = TU_W'(s1_x) * TU_W'(cfg.inv_width);
   assign tv_prod = TV_W'(s1_y) * TV_W'(cfg.inv_height);
   assign ny_prod = NY_W'(cfg.inv_width) * NY_W'(cfg.inv_height);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid) begin
         s2_nx_prod_ff  <= nx_prod;
         s2_nz_prod_ff  <= nz_prod;
         s2_tu_prod_ff  <= tu_prod;
         s2_tv_prod_ff  <= tv_prod;
         s2_ny_prod_ff  <= ny_prod;
         s2_height_ff   <= s1_item.height;
         s2_index_ff    <= s1_item.index;
         s2_face_ff     <= s1_item.face;
         // corners wrap modulo 2^20
         s2_corner_a_ff <= s1_item.index - INDEX_W'(cfg.width) - INDEX_W'(1);
         s2_corner_b_ff <= s1_item.index - INDEX_W'(1);
         s2_corner_d_ff <= s1_item.index - INDEX_W'(cfg.width);
      end
   end

   // round half up, floor shift
   assign nx_sum = s2_nx_prod_ff + NPROD_W'(2048);
   assign nz_sum = s2_nz_prod_ff + NPROD_W'(2048);
   assign ny_sum = s2_ny_prod_ff + NY_W'(32768);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s2_valid_ff) begin
         rsp_vertex_index_ff <= s2_index_ff;
         rsp_tex_u_ff <= (s2_tu_prod_ff > TU_W'(16'hFFFF)) ? 16'hFFFF
                                                           : s2_tu_prod_ff[TEX_W-1:0];
         rsp_tex_v_ff <= (s2_tv_prod_ff > TV_W'(16'hFFFF)) ? 16'hFFFF
                                                           : s2_tv_prod_ff[TEX_W-1:0];
         rsp_height_out_ff <= s2_height_ff;
         rsp_face_valid_ff <= s2_face_ff;
         if (s2_face_ff) begin
            rsp_normal_x_ff      <= nx_sum[NORM_W+11:12];
            rsp_normal_y_ff      <= ny_sum[INV_W+15:16];
            rsp_normal_z_ff      <= nz_sum[NORM_W+11:12];
            rsp_face_corner_a_ff <= s2_corner_a_ff;
            rsp_face_corner_b_ff <= s2_corner_b_ff;
            rsp_face_corner_c_ff <= s2_index_ff;
            rsp_face_corner_d_ff <= s2_corner_d_ff;
         end else begin
            // edge vertex: straight-up normal, no face
            rsp_normal_x_ff      <= '0;
            rsp_normal_y_ff      <= ONE_Q16;
            rsp_normal_z_ff      <= '0;
            rsp_face_corner_a_ff <= '0;
            rsp_face_corner_b_ff <= '0;
            rsp_face_corner_c_ff <= '0;
            rsp_face_corner_d_ff <= '0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vertex_index  = rsp_vertex_index_ff;
   assign rsp_tex_u         = rsp_tex_u_ff;
   assign rsp_tex_v         = rsp_tex_v_ff;
   assign rsp_height_out    = rsp_height_out_ff;
   assign rsp_normal_x      = rsp_normal_x_ff;
   assign rsp_normal_y      = rsp_normal_y_ff;
   assign rsp_normal_z      = rsp_normal_z_ff;
   assign rsp_face_valid    = rsp_face_valid_ff;
   assign rsp_face_corner_a = rsp_face_corner_a_ff;
   assign rsp_face_corner_b = rsp_face_corner_b_ff;
   assign rsp_face_corner_c = rsp_face_corner_c_ff;
   assign rsp_face_corner_d = rsp_face_corner_d_ff;

`ifndef NO_ASSERTIONS
   // a beat in the multiply stage is not dropped while the output stalls
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !out_ready) |=> (s2_valid_ff && $stable(s2_index_ff)))
      else $error("multiply stage lost a beat under stall");
`endif

endmodule

// File: rtl/heightmap_grid_mesh_normals_unit.sv
// Top level of the heightmap mesh and fast normal unit.
// Height samples enter in raster order, one beat per sample, and each sample
// yields one result beat: vertex index, texture coordinates, the height, the
// unnormalized finite-difference normal ((left-h)*invH, invW*invH,
// (upper-h)*invW) and the quad face that ends at this vertex. The first row
// and first column give normal (0, 65536, 0) and no face. The row buffer is
// one synchronous RAM of MAX_WIDTH heights; each accepted sample reads the
// entry of its column (the height one row up) and overwrites it with its own
// height on the same edge, so no forwarding is needed even for one-column
// grids. Throughput is one sample per clock unless a result stall holds it,
// set by that single row buffer access per sample; every later stage is fully
// pipelined. A sample passes three register stages (scan/RAM read, multiply,
// round/output), and rsp_valid rises once it reaches the round/output stage.
// A result stall reaches req_stall in the same cycle once the pipeline is
// full. The multiply stage is the deepest path: one 17x18 signed product each
// for the x and z normal components. The row buffer needs no clearing; a
// column is always written on row zero before its stored height is used. The
// scan position wraps after the last sample of the grid and is not moved by
// register writes. Configure only while the unit is idle.
module heightmap_grid_mesh_normals_unit #(
   parameter int MAX_WIDTH  = hgmn_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = hgmn_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample input
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [hgmn_pkg::HEIGHT_W-1:0] req_height_in,
   // result output
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [hgmn_pkg::INDEX_W-1:0]         rsp_vertex_index,
   output logic [hgmn_pkg::TEX_W-1:0]           rsp_tex_u,
   output logic [hgmn_pkg::TEX_W-1:0]           rsp_tex_v,
   output logic signed [hgmn_pkg::HEIGHT_W-1:0] rsp_height_out,
   output logic signed [hgmn_pkg::NORM_W-1:0]   rsp_normal_x,
   output logic [hgmn_pkg::INV_W-1:0]           rsp_normal_y,
   output logic signed [hgmn_pkg::NORM_W-1:0]   rsp_normal_z,
   output logic                                 rsp_face_valid,
   output logic [hgmn_pkg::INDEX_W-1:0]         rsp_face_corner_a,
   output logic [hgmn_pkg::INDEX_W-1:0]         rsp_face_corner_b,
   output logic [hgmn_pkg::INDEX_W-1:0]         rsp_face_corner_c,
   output logic [hgmn_pkg::INDEX_W-1:0]         rsp_face_corner_d,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hgmn_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [hgmn_pkg::CSR_DATA_W-1:0]      csr_data
);
   import hgmn_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   // compare widths: counter+1 against an 11-bit size
   localparam int COL_CMP_W = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W;
   localparam int ROW_CMP_W = (ROW_W + 1 > SIZE_W) ? ROW_W + 1 : SIZE_W;

   hgmn_cfg_type cfg;

   // scan position
   logic [COL_W-1:0]           col_ff;
   logic [ROW_W-1:0]           row_ff;
   logic [INDEX_W-1:0]         idx_ff;
   logic signed [HEIGHT_W-1:0] left_ff;
   logic [COL_W-1:0]           col_in;
   logic [ROW_W-1:0]           row_in;
   logic [INDEX_W-1:0]         idx_in;
   logic [COL_CMP_W-1:0]       col_inc;
   logic [ROW_CMP_W-1:0]       row_inc;
   logic                       col_wrap;
   logic                       row_wrap;

   // scan stage register
   logic                       s1_valid_ff;
   hgmn_item_type              s1_item_ff;
   logic [COL_W-1:0]           s1_x_ff;
   logic [ROW_W-1:0]           s1_y_ff;
   logic signed [HEIGHT_W-1:0] s1_upper;
   logic                       s1_ready;
   logic                       s1_free;
   logic                       accept;

   assign s1_free   = !s1_valid_ff || s1_ready;
   assign req_stall = !s1_free;
   assign accept    = req_valid && !req_stall;

   hgmn_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // row buffer: read upper neighbor, write this sample, one access per beat
   hgmn_row_mem #(
      .DEPTH (MAX_WIDTH)
   ) u_row_mem (
      .clock      (clock),
      .access_en  (accept),
      .addr       (col_ff),
      .wr_data    (req_height_in),
      .rd_data_ff (s1_upper)
   );

   // next position, wrapping at end of row and end of grid
   always_comb begin
      col_inc  = COL_CMP_W'(col_ff) + COL_CMP_W'(1);
      row_inc  = ROW_CMP_W'(row_ff) + ROW_CMP_W'(1);
      col_wrap = col_inc >= COL_CMP_W'(cfg.width);
      row_wrap = row_inc >= ROW_CMP_W'(cfg.height);
      col_in   = col_inc[COL_W-1:0];
      row_in   = row_ff;
      idx_in   = idx_ff + INDEX_W'(1);
      if (col_wrap) begin
         col_in = '0;
         row_in = row_inc[ROW_W-1:0];
         if (row_wrap) begin
            row_in = '0;
            idx_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         idx_ff  <= '0;
         left_ff <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         idx_ff  <= idx_in;
         left_ff <= req_height_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.height <= req_height_in;
         s1_item_ff.left   <= left_ff;
         s1_item_ff.index  <= idx_ff;
         s1_item_ff.face   <= (col_ff != '0) && (row_ff != '0);
         s1_x_ff           <= col_ff;
         s1_y_ff           <= row_ff;
      end
   end

   hgmn_arith #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_arith (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .s1_valid          (s1_valid_ff),
      .s1_ready          (s1_ready),
      .s1_item           (s1_item_ff),
      .s1_x              (s1_x_ff),
      .s1_y              (s1_y_ff),
      .s1_upper          (s1_upper),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_vertex_index  (rsp_vertex_index),
      .rsp_tex_u         (rsp_tex_u),
      .rsp_tex_v         (rsp_tex_v),
      .rsp_height_out    (rsp_height_out),
      .rsp_normal_x      (rsp_normal_x),
      .rsp_normal_y      (rsp_normal_y),
      .rsp_normal_z      (rsp_normal_z),
      .rsp_face_valid    (rsp_face_valid),
      .rsp_face_corner_a (rsp_face_corner_a),
      .rsp_face_corner_b (rsp_face_corner_b),
      .rsp_face_corner_c (rsp_face_corner_c),
      .rsp_face_corner_d (rsp_face_corner_d)
   );

`ifndef NO_ASSERTIONS
   // a new beat never lands on a scan stage that cannot move on
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!s1_valid_ff || s1_ready))
      else $error("scan stage overrun");

   // a held scan stage keeps its beat, so the RAM read data stays matched
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_ready) |=> (s1_valid_ff && $stable(s1_item_ff.index)))
      else $error("scan stage lost a beat under stall");

   // grid origin always carries vertex index zero
   a_origin_index: assert property (@(posedge clock) disable iff (reset)
      (col_ff == '0 && row_ff == '0) |-> (idx_ff == '0))
      else $error("vertex index out of step with scan position");
`endif

endmodule

// File: verif/heightmap_grid_mesh_normals_unit_test.sv
// Self-checking testbench for the heightmap mesh and fast normal unit.
module heightmap_grid_mesh_normals_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import hgmn_pkg::*;

   // Run limits. The slowest legal run is roughly 1600 beats, each waiting out
   // random sender gaps and result stalls; the limit is far above that.
   localparam int CYCLE_LIMIT   = 400_000;
   localparam int SETTLE_CYCLES = 8;      // pipeline is three deep
   localparam int CSR_INDEX_LAST = (1 << CSR_INDEX_W) - 1;
   localparam int CSR_PAD_W      = CSR_DATA_W - SIZE_W;

   // Height patterns for a grid of samples.
   typedef enum int {
      TERRAIN_NOISE,
      TERRAIN_SMOOTH,
      TERRAIN_EXTREME
   } terrain_kind_type;

   // One expected result beat, at the port widths.
   typedef struct {
      logic [INDEX_W-1:0]  vertex_index;
      logic [TEX_W-1:0]    tex_u;
      logic [TEX_W-1:0]    tex_v;
      logic [HEIGHT_W-1:0] height_out;
      logic [NORM_W-1:0]   normal_x;
      logic [INV_W-1:0]    normal_y;
      logic [NORM_W-1:0]   normal_z;
      logic                face_valid;
      logic [INDEX_W-1:0]  face_corner_a;
      logic [INDEX_W-1:0]  face_corner_b;
      logic [INDEX_W-1:0]  face_corner_c;
      logic [INDEX_W-1:0]  face_corner_d;
   } mesh_vertex_type;

   // ------------------------------------------------------------------
   // DUT signals; every input has a known value from time zero.
   // ------------------------------------------------------------------
   logic                        clock;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [HEIGHT_W-1:0]  req_height_in = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [INDEX_W-1:0]          rsp_vertex_index;
   logic [TEX_W-1:0]            rsp_tex_u;
   logic [TEX_W-1:0]            rsp_tex_v;
   logic signed [HEIGHT_W-1:0]  rsp_height_out;
   logic signed [NORM_W-1:0]    rsp_normal_x;
   logic [INV_W-1:0]            rsp_normal_y;
   logic signed [NORM_W-1:0]    rsp_normal_z;
   logic                        rsp_face_valid;
   logic [INDEX_W-1:0]          rsp_face_corner_a;
   logic [INDEX_W-1:0]          rsp_face_corner_b;
   logic [INDEX_W-1:0]          rsp_face_corner_c;
   logic [INDEX_W-1:0]          rsp_face_corner_d;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index = CSR_GRID_WIDTH;
   logic [CSR_DATA_W-1:0]       csr_data = '0;

   heightmap_grid_mesh_normals_unit i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Mesh predictor: its own copy of the registers and the scan state.
   // ------------------------------------------------------------------
   int unsigned grid_width_reg, grid_height_reg, inv_width_reg, inv_height_reg;
   logic signed [HEIGHT_W-1:0] row_heights [DEF_MAX_WIDTH];
   logic signed [HEIGHT_W-1:0] left_height;
   int unsigned scan_col, scan_row;
   logic [INDEX_W-1:0] scan_index;

   mesh_vertex_type pending_vertices [$];   // results owed by the unit, oldest first

   int idle_pct;        // chance in 100 that the sender idles a cycle
   int stall_pct;       // chance in 100 that the result side stalls a cycle
   int samples_sent;
   int mismatch_count;
   int cycle_count;
   int walk_height;

   // Size 0 acts as 1, sizes past the buffer act as the buffer size.
   function automatic int unsigned clamp_size(int unsigned raw, int unsigned limit);
      if (raw == 0) return 1;
      return (raw > limit) ? limit : raw;
   endfunction

   function automatic int unsigned clamp_recip(int unsigned raw);
      return (raw > ONE_Q16) ? ONE_Q16 : raw;
   endfunction

   function automatic logic [TEX_W-1:0] saturate_tex(longint product);
      return (product > 65535) ? 16'hFFFF : product[TEX_W-1:0];
   endfunction

   // (diff * recip + 2048) >> 12, floor shift, kept to the port width
   function automatic logic [NORM_W-1:0] scale_slope(int diff, int unsigned recip);
      longint p;
      p = (longint'(diff) * longint'(recip) + 2048) >>> 12;
      return p[NORM_W-1:0];
   endfunction

   function automatic void reset_mesh_model();
      grid_width_reg  = 1;
      grid_height_reg = 1;
      inv_width_reg   = ONE_Q16;
      inv_height_reg  = ONE_Q16;
      left_height     = '0;
      scan_col        = 0;
      scan_row        = 0;
      scan_index      = '0;
   endfunction

   // Expected beat for one accepted sample; advances the raster position.
   function automatic mesh_vertex_type compute_vertex(logic signed [HEIGHT_W-1:0] hgt);
      mesh_vertex_type v;
      int unsigned w, h, iw, ih, x, y;
      logic [INDEX_W-1:0] idx;
      logic signed [HEIGHT_W-1:0] upper;
      w   = clamp_size(grid_width_reg, DEF_MAX_WIDTH);
      h   = clamp_size(grid_height_reg, DEF_MAX_HEIGHT);
      iw  = clamp_recip(inv_width_reg);
      ih  = clamp_recip(inv_height_reg);
      x   = scan_col;
      y   = scan_row;
      idx = scan_index;
      upper = (x < DEF_MAX_WIDTH) ? row_heights[x] : '0;

      v.vertex_index = idx;
      v.tex_u        = saturate_tex(longint'(x) * longint'(iw));
      v.tex_v        = saturate_tex(longint'(y) * longint'(ih));
      v.height_out   = hgt;
      if (x >= 1 && y >= 1) begin
         v.normal_x      = scale_slope(int'(left_height) - int'(hgt), ih);
         v.normal_y      = INV_W'((longint'(iw) * longint'(ih) + 32768) >> 16);
         v.normal_z      = scale_slope(int'(upper) - int'(hgt), iw);
         v.face_valid    = 1'b1;
         v.face_corner_a = INDEX_W'(idx - w - 1);
         v.face_corner_b = INDEX_W'(idx - 1);
         v.face_corner_c = idx;
         v.face_corner_d = INDEX_W'(idx - w);
      end else begin
         // edge vertex: straight-up normal, no face
         v.normal_x      = '0;
         v.normal_y      = ONE_Q16;
         v.normal_z      = '0;
         v.face_valid    = 1'b0;
         v.face_corner_a = '0;
         v.face_corner_b = '0;
         v.face_corner_c = '0;
         v.face_corner_d = '0;
      end

      if (x < DEF_MAX_WIDTH) row_heights[x] = hgt;
      left_height = hgt;
      if (x + 1 >= w) begin
         scan_col = 0;
         if (y + 1 >= h) begin
            scan_row   = 0;
            scan_index = '0;
         end else begin
            scan_row   = y + 1;
            scan_index = INDEX_W'(idx + 1);
         end
      end else begin
         scan_col   = x + 1;
         scan_index = INDEX_W'(idx + 1);
      end
      return v;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers. Inputs change on the falling edge only.
   // ------------------------------------------------------------------
   task automatic send_sample(logic signed [HEIGHT_W-1:0] hgt);
      @(negedge clock);
      // random sender gaps; each lowering falls on its own falling edge
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_height_in <= hgt;
      do @(posedge clock); while (req_stall);
      pending_vertices.push_back(compute_vertex(hgt));
      samples_sent++;
   endtask

   // Stop sending and wait for every owed beat to come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GRID_WIDTH:  grid_width_reg  = 32'(value[SIZE_W-1:0]);
         CSR_GRID_HEIGHT: grid_height_reg = 32'(value[SIZE_W-1:0]);
         CSR_INV_WIDTH:   inv_width_reg   = 32'(value[INV_W-1:0]);
         CSR_INV_HEIGHT:  inv_height_reg  = 32'(value[INV_W-1:0]);
         default: ;   // spare index, ignored by the unit
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Registers change only with the pipeline empty.
   task automatic configure_grid(logic [CSR_DATA_W-1:0] width, logic [CSR_DATA_W-1:0] height,
                                 logic [CSR_DATA_W-1:0] inv_w, logic [CSR_DATA_W-1:0] inv_h);
      wait_drained();
      write_register(CSR_GRID_WIDTH, width);
      write_register(CSR_GRID_HEIGHT, height);
      write_register(CSR_INV_WIDTH, inv_w);
      write_register(CSR_INV_HEIGHT, inv_h);
   endtask

   function automatic logic signed [HEIGHT_W-1:0] next_height(terrain_kind_type kind);
      case (kind)
         TERRAIN_SMOOTH: begin
            walk_height += int'($urandom_range(1024)) - 512;
            if (walk_height > 32767) walk_height = 32767;
            if (walk_height < -32768) walk_height = -32768;
            return HEIGHT_W'(walk_height);
         end
         TERRAIN_EXTREME: begin
            case ($urandom_range(4))
               0: return 16'sh7FFF;
               1: return 16'sh8000;
               2: return 16'sh0000;
               3: return 16'shFFFF;
               default: return HEIGHT_W'($urandom());
            endcase
         end
         default: return HEIGHT_W'($urandom());
      endcase
   endfunction

   // Keep sending until the raster position is back at the origin.
   task automatic finish_grid(terrain_kind_type kind);
      do begin
         // now and then hold the sender until the unit has caught up
         if ($urandom_range(63) == 0) wait_drained();
         send_sample(next_height(kind));
      end while (scan_col != 0 || scan_row != 0);
   endtask

   // Reciprocal choice: exact, zero, one, anything up to one, or anything the register holds.
   function automatic logic [CSR_DATA_W-1:0] pick_reciprocal(int unsigned size);
      case ($urandom_range(5))
         0: return '0;
         1: return ONE_Q16;
         2: return CSR_DATA_W'($urandom_range(131071));
         3: return CSR_DATA_W'($urandom_range(65536));
         default: return CSR_DATA_W'((65536 + size / 2) / size);
      endcase
   endfunction

   task automatic randomize_grid();
      int unsigned w_raw, h_raw, w_eff, h_eff, h_max;
      logic [CSR_DATA_W-1:0] w_word, h_word;
      case ($urandom_range(19))
         0:       w_raw = 0;
         1, 2:    w_raw = $urandom_range(17, 48);
         default: w_raw = $urandom_range(1, 16);
      endcase
      w_eff = clamp_size(w_raw, DEF_MAX_WIDTH);
      h_max = 160 / w_eff;
      if (h_max > 12) h_max = 12;
      if (h_max < 1) h_max = 1;
      h_raw = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, h_max);
      h_eff = clamp_size(h_raw, DEF_MAX_HEIGHT);
      // junk above the size field is dropped by the register
      w_word = {CSR_PAD_W'($urandom()), SIZE_W'(w_raw)};
      h_word = {CSR_PAD_W'($urandom()), SIZE_W'(h_raw)};
      if ($urandom_range(3) != 0) w_word = CSR_DATA_W'(w_raw);
      if ($urandom_range(3) != 0) h_word = CSR_DATA_W'(h_raw);
      configure_grid(w_word, h_word, pick_reciprocal(w_eff), pick_reciprocal(h_eff));
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset values: 1x1 grid, so every sample is an edge vertex at the origin.
   task automatic test_power_on_defaults();
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      send_sample(16'shFFFF);
   endtask

   // Checkerboard of the height extremes gives the largest slopes both ways;
   // reciprocals above one clamp, and x/W, y/H saturate.
   task automatic test_slope_extremes();
      configure_grid(3, 3, 17'h1FFFF, 17'h10001);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            send_sample(((r + c) % 2) ? 16'sh8000 : 16'sh7FFF);
   endtask

   // Zero sizes act as one; writes to spare indexes change nothing.
   task automatic test_degenerate_sizes();
      configure_grid(0, 0, 0, 0);
      send_sample(16'sh1234);
      send_sample(16'shEDCC);
      configure_grid(2, 2, 32768, 32768);
      for (int i = CSR_INV_HEIGHT + 1; i <= CSR_INDEX_LAST; i++)
         write_register(i[CSR_INDEX_W-1:0], '1);
      finish_grid(TERRAIN_EXTREME);
   endtask

   // Oversized width and height clamp to the buffer size. Shrinking the grid
   // mid-row leaves the position alone; the next sample wraps it home.
   task automatic test_oversize_sizes();
      configure_grid(17'h1FFFF, 0, 64, 0);
      repeat (4) send_sample(next_height(TERRAIN_NOISE));
      wait_drained();
      write_register(CSR_GRID_WIDTH, 2);
      finish_grid(TERRAIN_NOISE);
      configure_grid(1, 17'h1FFFF, 0, 40000);
      repeat (3) send_sample(next_height(TERRAIN_NOISE));
      wait_drained();
      write_register(CSR_GRID_HEIGHT, 1);
      finish_grid(TERRAIN_NOISE);
   endtask

   // Whole grids of random size and content under one idling pattern.
   task automatic test_random_terrain(int sender_idle, int receiver_stall, int count);
      int start;
      terrain_kind_type kind;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      start     = samples_sent;
      while (samples_sent - start < count) begin
         randomize_grid();
         kind = terrain_kind_type'($urandom_range(2));
         walk_height = int'(next_height(TERRAIN_NOISE));
         repeat ($urandom_range(1, 3)) finish_grid(kind);
      end
   endtask

   // ------------------------------------------------------------------
   // Result side: random stall, and the check of each accepted beat.
   // ------------------------------------------------------------------
   always @(negedge clock)
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

   task automatic report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want,
                              logic [INDEX_W-1:0] vertex);
      if (got !== want)
         report_mismatch($sformatf("vertex %0d %s: got 0x%0h, expected 0x%0h",
                                   vertex, name, got, want));
   endtask

   always @(posedge clock) begin
      mesh_vertex_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_vertices.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing owed, vertex %0d",
                                      rsp_vertex_index));
         end else begin
            want = pending_vertices.pop_front();
            check_field("vertex_index", 32'(rsp_vertex_index), 32'(want.vertex_index),
                        want.vertex_index);
            check_field("tex_u", 32'(rsp_tex_u), 32'(want.tex_u), want.vertex_index);
            check_field("tex_v", 32'(rsp_tex_v), 32'(want.tex_v), want.vertex_index);
            check_field("height_out", 32'($unsigned(rsp_height_out)), 32'(want.height_out),
                        want.vertex_index);
            check_field("normal_x", 32'($unsigned(rsp_normal_x)), 32'(want.normal_x),
                        want.vertex_index);
            check_field("normal_y", 32'(rsp_normal_y), 32'(want.normal_y), want.vertex_index);
            check_field("normal_z", 32'($unsigned(rsp_normal_z)), 32'(want.normal_z),
                        want.vertex_index);
            check_field("face_valid", 32'(rsp_face_valid), 32'(want.face_valid),
                        want.vertex_index);
            check_field("face_corner_a", 32'(rsp_face_corner_a), 32'(want.face_corner_a),
                        want.vertex_index);
            check_field("face_corner_b", 32'(rsp_face_corner_b), 32'(want.face_corner_b),
                        want.vertex_index);
            check_field("face_corner_c", 32'(rsp_face_corner_c), 32'(want.face_corner_c),
                        want.vertex_index);
            check_field("face_corner_d", 32'(rsp_face_corner_d), 32'(want.face_corner_d),
                        want.vertex_index);
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("heightmap_grid_mesh_normals_unit regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      idle_pct       = 0;
      stall_pct      = 0;
      samples_sent   = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      walk_height    = 0;
      reset_mesh_model();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, no idling
      test_power_on_defaults();
      test_slope_extremes();
      test_degenerate_sizes();
      test_oversize_sizes();

      // random part, one idling pattern per phase; the last grids of a phase
      // overshoot its count by some dozens of samples
      test_random_terrain(0, 0, 300);
      test_random_terrain(70, 0, 300);
      test_random_terrain(0, 70, 300);
      test_random_terrain(28, 28, 300);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("heightmap_grid_mesh_normals_unit regression: pass");
      else
         $display("heightmap_grid_mesh_normals_unit regression: fail");
      $finish;
   end

endmodule
